@@ hdl/oqmr_pkg.sv @@
// Shared types, codes and sizes for the ordered match-and-remove queue.
package oqmr_pkg;

   // Number of cells in the queue chain.
   localparam int QueueDepth = 16;

   // Command codes carried by a request transaction.
   localparam logic [1:0] CMD_APPEND     = 2'd0;
   localparam logic [1:0] CMD_REMOVE_CAT = 2'd1;
   localparam logic [1:0] CMD_REMOVE_DST = 2'd2;

   // Status codes returned in a response transaction.
   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   // One stored queue entry.
   typedef struct packed {
      logic [15:0] tag;
      logic [3:0]  category;
      logic [7:0]  destination;
   } entry_type;

   // What one cell shows its older neighbor: occupancy and contents.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } cell_type;

   // Operation broadcast to every cell in the cycle a request is accepted.
   typedef struct packed {
      logic      append;
      logic      remove_cat;
      logic      remove_dst;
      entry_type key;
   } op_type;

endpackage

@@ hdl/oqmr_cell.sv @@
// One queue cell: holds an entry, compares it against the key and shifts up on removal.
module oqmr_cell (
   input  logic              clock,
   input  logic              reset,
   input  oqmr_pkg::op_type  op,
   input  logic              prev_valid,
   input  logic              found_in,
   input  oqmr_pkg::cell_type next,
   output oqmr_pkg::cell_type cell_out,
   output logic              found_out,
   output logic              hit
);

   logic                valid_ff;
   logic                valid_in;
   oqmr_pkg::entry_type entry_ff;
   oqmr_pkg::entry_type entry_in;
   logic                shift;
   logic                load;

   // Key compare, oldest-match chain, and the shift and load decisions.
   always_comb begin
      hit = valid_ff &&
            ((op.remove_cat && (entry_ff.category == op.key.category)) ||
             (op.remove_dst && (entry_ff.destination == op.key.destination)));
      found_out = found_in || hit;
      shift = (op.remove_cat || op.remove_dst) && (found_in || hit);
      load  = op.append && !valid_ff && prev_valid;
   end

   // Next contents: take the younger neighbor on a shift, the new entry on an append.
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (shift) begin
         valid_in = next.valid;
         entry_in = next.entry;
      end else if (load) begin
         valid_in = 1'b1;
         entry_in = op.key;
      end
   end

   // The occupancy bit is reset; the entry contents are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign cell_out.valid = valid_ff;
   assign cell_out.entry = entry_ff;

endmodule

@@ hdl/ordered_queue_match_remove.sv @@
// Top level of the ordered queue with append and oldest-match removal.
//
//   Channel | Direction | Handshake           | Payload
//   req     | in        | req_valid/req_stall | command, person_tag, category, destination
//   rsp     | out       | rsp_valid/rsp_stall | status, removed_tag, removed_category,
//           |           |                     | removed_destination
//
// Each request transaction is applied to all cells at the accepting edge, and its response
// is registered at that same edge, shown from the next cycle on. This rests on the parallel
// key compare in every cell and the oldest-match chain that runs through the row of cells.
// A new request is taken while the response register
// is empty or being drained in the same cycle. Reset clears the occupancy bit of every
// cell at once; there is no clearing pass. A stall on rsp holds the response and stalls req.
module ordered_queue_match_remove (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_person_tag,
   input  logic [3:0]  req_category,
   input  logic [7:0]  req_destination,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_removed_tag,
   output logic [3:0]  rsp_removed_category,
   output logic [7:0]  rsp_removed_destination
);

   localparam int Depth = oqmr_pkg::QueueDepth;

   logic                 accept;
   oqmr_pkg::op_type     op;
   oqmr_pkg::cell_type   cells [Depth];
   oqmr_pkg::cell_type   next_of [Depth];
   logic [Depth-1:0]     prev_valid;
   logic [Depth:0]       found_chain;
   logic [Depth-1:0]     hit_vec;
   logic [Depth-1:0]     valid_vec;
   oqmr_pkg::entry_type  removed;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [1:0]           status_ff;
   logic [1:0]           status_in;
   oqmr_pkg::entry_type  removed_ff;
   oqmr_pkg::entry_type  removed_in;

   // Handshake: take a request while the response register is free or draining.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Decode the accepted request into the operation seen by every cell.
   always_comb begin
      op.append     = accept && (req_command == oqmr_pkg::CMD_APPEND);
      op.remove_cat = accept && (req_command == oqmr_pkg::CMD_REMOVE_CAT);
      op.remove_dst = accept && (req_command == oqmr_pkg::CMD_REMOVE_DST);
      op.key.tag         = req_person_tag;
      op.key.category    = req_category;
      op.key.destination = req_destination;
   end

   assign found_chain[0] = 1'b0;

   // The row of cells, oldest entry at cell zero.
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_valid[i] = 1'b1;
      end else begin : g_body
         assign prev_valid[i] = cells[i-1].valid;
      end
      if (i == Depth - 1) begin : g_tail
         assign next_of[i] = '0;
      end else begin : g_link
         assign next_of[i] = cells[i+1];
      end
      assign valid_vec[i] = cells[i].valid;

      oqmr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .prev_valid (prev_valid[i]),
         .found_in   (found_chain[i]),
         .next       (next_of[i]),
         .cell_out   (cells[i]),
         .found_out  (found_chain[i+1]),
         .hit        (hit_vec[i])
      );
   end

   // Select the fields of the removed entry; at most one cell is the oldest hit.
   always_comb begin
      removed = '0;
      for (int i = 0; i < Depth; i++) begin
         if (hit_vec[i] && !found_chain[i]) begin
            removed = removed | cells[i].entry;
         end
      end
   end

   // Build the response for the accepted request.
   always_comb begin
      status_in  = status_ff;
      removed_in = removed_ff;
      if (accept) begin
         removed_in = '0;
         case (req_command)
            oqmr_pkg::CMD_APPEND: begin
               status_in = cells[Depth-1].valid ? oqmr_pkg::STATUS_FULL
                                                : oqmr_pkg::STATUS_DONE;
            end
            oqmr_pkg::CMD_REMOVE_CAT: begin
               status_in = found_chain[Depth] ? oqmr_pkg::STATUS_DONE
                                              : oqmr_pkg::STATUS_NO_MATCH;
            end
            oqmr_pkg::CMD_REMOVE_DST: begin
               status_in = found_chain[Depth] ? oqmr_pkg::STATUS_DONE
                                              : oqmr_pkg::STATUS_NO_MATCH;
               removed_in = removed;
            end
            default: begin
               status_in = oqmr_pkg::STATUS_NO_MATCH;
            end
         endcase
      end
   end

   // Response valid: set by an accepted request, cleared when the response is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      removed_ff <= removed_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_removed_tag         = removed_ff.tag;
   assign rsp_removed_category    = removed_ff.category;
   assign rsp_removed_destination = removed_ff.destination;

`ifndef SYNTHESIS
   // Occupied cells always form one unbroken run from the head.
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + {{Depth{1'b0}}, 1'b1}))
      else $error("queue occupancy has a hole");

   // A removal never matches more than one cell as the oldest.
   a_single_remove: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec & ~found_chain[Depth-1:0]))
      else $error("more than one cell selected for removal");

   // An append into a queue with room grows the occupancy by one.
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (op.append && !cells[Depth-1].valid) |=>
         ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
      else $error("append did not add exactly one entry");

   // A successful removal shrinks the occupancy by one.
   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      ((op.remove_cat || op.remove_dst) && found_chain[Depth]) |=>
         ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
      else $error("removal did not delete exactly one entry");
`endif

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the ordered match-and-remove queue.
`timescale 1ns / 1ps

module tb_top;

   // Command code the block does not use; it must be ignored.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RandomItems = 1850;
   localparam int CycleLimit = 400000;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;
   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_type;

   // Fields of one response transaction.
   typedef struct packed {
      logic [1:0]          status;
      oqmr_pkg::entry_type removed;
   } rsp_fields_type;

   // Mirror of the queue contents plus the responses still owed by the block.
   class queue_scoreboard_type;
      oqmr_pkg::entry_type shadow[$];
      rsp_fields_type      pending_rsp[$];
      int errors = 0;
      int reported = 0;
      int checked = 0;
      int appends = 0;
      int fulls = 0;
      int cat_hits = 0;
      int dst_hits = 0;
      int misses = 0;
      int ignored = 0;
      int peak = 0;

      // Apply one accepted request to the mirror and queue up its response.
      function void note_request(logic [1:0] cmd, oqmr_pkg::entry_type key);
         rsp_fields_type want;
         int hit;
         logic match;
         want.status = oqmr_pkg::STATUS_NO_MATCH;
         want.removed = '0;
         hit = -1;
         case (cmd)
            oqmr_pkg::CMD_APPEND: begin
               if (shadow.size() >= oqmr_pkg::QueueDepth) begin
                  want.status = oqmr_pkg::STATUS_FULL;
                  fulls++;
               end else begin
                  shadow.push_back(key);
                  want.status = oqmr_pkg::STATUS_DONE;
                  appends++;
               end
            end
            oqmr_pkg::CMD_REMOVE_CAT, oqmr_pkg::CMD_REMOVE_DST: begin
               // Only the oldest matching entry goes; younger ones close the gap.
               for (int i = 0; i < shadow.size() && hit < 0; i++) begin
                  match = (cmd == oqmr_pkg::CMD_REMOVE_CAT)
                        ? (shadow[i].category == key.category)
                        : (shadow[i].destination == key.destination);
                  if (match) hit = i;
               end
               if (hit >= 0) begin
                  if (cmd == oqmr_pkg::CMD_REMOVE_DST) begin
                     want.removed = shadow[hit];
                     dst_hits++;
                  end else begin
                     cat_hits++;
                  end
                  want.status = oqmr_pkg::STATUS_DONE;
                  shadow.delete(hit);
               end else begin
                  misses++;
               end
            end
            default: begin
               ignored++;
            end
         endcase
         if (shadow.size() > peak) peak = shadow.size();
         pending_rsp.push_back(want);
      endfunction

      // Compare one accepted response against the oldest outstanding one.
      function void check_response(rsp_fields_type got);
         rsp_fields_type want;
         logic bad;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("ERROR: response with nothing outstanding: status=%0d tag=%h cat=%h dst=%h",
                        got.status, got.removed.tag, got.removed.category,
                        got.removed.destination);
            end
            return;
         end
         want = pending_rsp.pop_front();
         checked++;
         bad = (got.status !== want.status) || (got.removed.tag !== want.removed.tag) ||
               (got.removed.category !== want.removed.category) ||
               (got.removed.destination !== want.removed.destination);
         if (bad) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("MISMATCH on response %0d: expected status=%0d tag=%h cat=%h dst=%h",
                        checked, want.status, want.removed.tag, want.removed.category,
                        want.removed.destination);
               $display("                        actual   status=%0d tag=%h cat=%h dst=%h",
                        got.status, got.removed.tag, got.removed.category,
                        got.removed.destination);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = oqmr_pkg::CMD_APPEND;
   logic [15:0] req_person_tag = '0;
   logic [3:0]  req_category = '0;
   logic [7:0]  req_destination = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_removed_tag;
   logic [3:0]  rsp_removed_category;
   logic [7:0]  rsp_removed_destination;

   queue_scoreboard_type sb = new;
   int cycles = 0;

   ordered_queue_match_remove u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_command            (req_command),
      .req_person_tag         (req_person_tag),
      .req_category           (req_category),
      .req_destination        (req_destination),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_removed_tag        (rsp_removed_tag),
      .rsp_removed_category   (rsp_removed_category),
      .rsp_removed_destination(rsp_removed_destination)
   );

   always #1 clock = ~clock;

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycles, sb.pending_rsp.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Both channels are observed at the edge: responses first, then the new request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response({rsp_status, rsp_removed_tag, rsp_removed_category,
                               rsp_removed_destination});
         end
         if (req_valid && !req_stall) begin
            sb.note_request(req_command, {req_person_tag, req_category, req_destination});
         end
      end
   end

   // The receiver switches between stall patterns of random length.
   stall_mode_type stall_mode = STALL_NONE;
   int stall_left = 0;
   int stall_phase = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(50, 300);
      end else begin
         stall_left--;
      end
      stall_phase = (stall_phase + 1) % 5;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 30);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 75);
         default:     rsp_stall <= (stall_phase < 3);
      endcase
   end

   // Present one request at the falling edge and hold it until it is taken.
   task automatic send_item(input logic [1:0] cmd, input oqmr_pkg::entry_type item);
      req_valid = 1'b1;
      req_command = cmd;
      req_person_tag = item.tag;
      req_category = item.category;
      req_destination = item.destination;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Random request; removal keys mostly come from live entries so they hit.
   function automatic void pick_item(input traffic_mix_type mix, output logic [1:0] cmd,
                                     output oqmr_pkg::entry_type item);
      int roll;
      int append_pct;
      oqmr_pkg::entry_type victim;
      roll = $urandom_range(0, 99);
      append_pct = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 25 : 50;
      item.tag = 16'($urandom);
      item.category = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3))
                                                 : 4'($urandom_range(0, 15));
      item.destination = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7))
                                                    : 8'($urandom_range(0, 255));
      if (roll < 2) begin
         cmd = CMD_UNUSED;
      end else if (roll < append_pct) begin
         cmd = oqmr_pkg::CMD_APPEND;
      end else begin
         cmd = ($urandom_range(0, 1) == 0) ? oqmr_pkg::CMD_REMOVE_CAT
                                           : oqmr_pkg::CMD_REMOVE_DST;
         if (sb.shadow.size() > 0 && $urandom_range(0, 99) < 80) begin
            victim = sb.shadow[$urandom_range(0, sb.shadow.size() - 1)];
            item.category = victim.category;
            item.destination = victim.destination;
         end
      end
   endfunction

   initial begin
      logic [1:0]          cmd;
      oqmr_pkg::entry_type item;
      traffic_mix_type     mix;
      int mix_left;
      int burst_left;
      int gap;
      int counted;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Removals and the unused command on an empty queue.
      send_item(oqmr_pkg::CMD_REMOVE_CAT, {16'h1234, 4'h0, 8'h00});
      send_item(oqmr_pkg::CMD_REMOVE_DST, {16'h5678, 4'h0, 8'h00});
      send_item(CMD_UNUSED, {16'hFFFF, 4'hF, 8'hFF});

      // Fill to capacity with field extremes and repeated keys.
      for (int i = 0; i < oqmr_pkg::QueueDepth; i++) begin
         item.tag = 16'($urandom);
         item.category = 4'(i % 4);
         item.destination = 8'(i % 6);
         if (i == 0) item = '0;
         if (i == 1) item = {16'hFFFF, 4'hF, 8'hFF};
         send_item(oqmr_pkg::CMD_APPEND, item);
      end

      // Append to a full queue, then the unused command with the queue full.
      send_item(oqmr_pkg::CMD_APPEND, {16'hA5A5, 4'h5, 8'h5A});
      send_item(CMD_UNUSED, {16'h0F0F, 4'h3, 8'h03});

      // Keys that match nothing, keys that match several entries, then the extreme entry.
      send_item(oqmr_pkg::CMD_REMOVE_CAT, {16'h0000, 4'hA, 8'h00});
      send_item(oqmr_pkg::CMD_REMOVE_DST, {16'h0000, 4'h0, 8'h80});
      send_item(oqmr_pkg::CMD_REMOVE_CAT, {16'hFFFF, 4'h2, 8'hFF});
      send_item(oqmr_pkg::CMD_REMOVE_DST, {16'hFFFF, 4'hF, 8'h03});
      send_item(oqmr_pkg::CMD_REMOVE_DST, {16'h0000, 4'h0, 8'hFF});

      // Random traffic in bursts, with the fill/drain balance changing over time.
      counted = 0;
      burst_left = 0;
      mix_left = 0;
      mix = MIX_FILL;
      while (counted < RandomItems) begin
         if (mix_left == 0) begin
            mix = traffic_mix_type'($urandom_range(0, 2));
            mix_left = $urandom_range(40, 200);
         end
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_valid = 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         pick_item(mix, cmd, item);
         send_item(cmd, item);
         burst_left--;
         mix_left--;
         if (cmd != CMD_UNUSED) counted++;
      end
      req_valid = 1'b0;

      // Drain the outstanding responses, then wait on for stray responses.
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      sb.errors += sb.pending_rsp.size();

      $display("Checked %0d responses: %0d appends, %0d rejected as full, %0d ignored",
               sb.checked, sb.appends, sb.fulls, sb.ignored);
      $display("Removals: %0d by category, %0d by destination, %0d without match; peak %0d",
               sb.cat_hits, sb.dst_hits, sb.misses, sb.peak);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d errors found", sb.errors);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/oqmr_pkg.sv
hdl/oqmr_cell.sv
hdl/ordered_queue_match_remove.sv
bench/tb_top.sv
